### hw/rtl/swrt_pkg.sv
// swrt_pkg: shared types and constants of the sliding window rank tracker
// no dependencies; imported by the interfaces and the tracker module
`default_nettype none

package swrt_pkg;

  // fixed field widths
  localparam int CMD_W      = 3;
  localparam int HOST_IDX_W = 3;
  localparam int MASK_W     = 8;
  localparam int TIME_W     = 32;
  localparam int COUNT_W    = 7;
  localparam int WL_W       = 7;
  localparam int RANK_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  typedef logic [CMD_W-1:0]     cmd_t;
  typedef logic [TIME_W-1:0]    sample_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // command codes
  localparam cmd_t CMD_ADD_ONE   = 3'd0;
  localparam cmd_t CMD_ADD_MASK  = 3'd1;
  localparam cmd_t CMD_PRED_ONE  = 3'd2;
  localparam cmd_t CMD_PRED_MASK = 3'd3;
  localparam cmd_t CMD_STATS     = 3'd4;

  // register indexes
  localparam cfg_idx_t CFG_WINDOW_LENGTH = 2'd0;
  localparam cfg_idx_t CFG_RANK_FROM_TOP = 2'd1;

  localparam logic [WL_W-1:0] WL_RESET = 7'd64;

  // nearest-rank percentiles, ceil(k*n/100) via reciprocal of 100
  localparam logic [6:0] PCT_MID   = 7'd50;
  localparam logic [6:0] PCT_HIGH  = 7'd90;
  localparam logic [6:0] PCT_TOP   = 7'd99;
  localparam logic [6:0] PCT_ROUND = 7'd99;
  localparam int RECIP_W     = 18;
  localparam int RECIP_SHIFT = 24;
  localparam logic [RECIP_W-1:0] RECIP_100 = 18'd167773;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HOST,
    ST_ADD_OLD,
    ST_REM,
    ST_INS_GO,
    ST_INS,
    ST_INS_LAST,
    ST_PRED_CMP,
    ST_STAT_CHK,
    ST_STAT_X,
    ST_STAT_MUL,
    ST_STAT_RD,
    ST_STAT_CAP,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    STEP_MIN,
    STEP_MAX,
    STEP_P50,
    STEP_P90,
    STEP_P99
  } stat_step_t;

endpackage

`default_nettype wire

### hw/rtl/swrt_if.sv
// swrt channel interfaces: request, response and register write channels
// depends on swrt_pkg for field widths
`default_nettype none

interface swrt_req_if;
  import swrt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CMD_W-1:0]      command;
  logic [HOST_IDX_W-1:0] host_index;
  logic [MASK_W-1:0]     host_mask;
  logic [TIME_W-1:0]     sample_time;
  modport source (output valid, command, host_index, host_mask, sample_time, input ready);
  modport sink   (input valid, command, host_index, host_mask, sample_time, output ready);
endinterface

interface swrt_rsp_if;
  import swrt_pkg::*;
  logic               valid;
  logic               ready;
  logic [TIME_W-1:0]  predicted_time;
  logic [COUNT_W-1:0] sample_count;
  logic [TIME_W-1:0]  min_time;
  logic [TIME_W-1:0]  max_time;
  logic [TIME_W-1:0]  p50_time;
  logic [TIME_W-1:0]  p90_time;
  logic [TIME_W-1:0]  p99_time;
  modport source (output valid, predicted_time, sample_count, min_time, max_time,
                  p50_time, p90_time, p99_time, input ready);
  modport sink   (input valid, predicted_time, sample_count, min_time, max_time,
                  p50_time, p90_time, p99_time, output ready);
endinterface

interface swrt_cfg_if;
  import swrt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/swrt_ram.sv
// swrt_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
`default_nettype none

module swrt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/sliding_window_rank_tracker.sv
// sliding_window_rank_tracker: per-host sliding window with sorted copy
// depends on swrt_pkg, swrt_if (channels) and swrt_ram (sorted copy, arrival ring)
// add: per selected host, a full window reads the oldest sample from the ring, removes
//   it from the sorted copy and inserts the new one; a window not yet full only inserts;
//   predict: reads the ranked sample of each selected host and keeps the largest;
//   statistics: min, max, p50, p90, p99 in turn, an empty host answers at once;
//   unselected hosts are skipped; the sorted ram takes one read and one write per cycle
// throughput: one word at a time, the next word is taken once the sequencer is idle
// reset: control state, counts, ring heads cleared, registers reset, rams not cleared
`default_nettype none

module sliding_window_rank_tracker #(
  parameter int WINDOW_MAX = 64,
  parameter int HOSTS      = 8
) (
  input wire logic   clk,
  input wire logic   rst,
  swrt_req_if.sink   req,
  swrt_rsp_if.source rsp,
  swrt_cfg_if.sink   cfg
);
  import swrt_pkg::*;

  localparam int HW    = (HOSTS > 1) ? $clog2(HOSTS) : 1;
  localparam int IW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW    = $clog2(WINDOW_MAX + 1);
  localparam int CAPW  = (CW > WL_W) ? CW : WL_W;
  localparam int DEPTH = HOSTS * WINDOW_MAX;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = $clog2(99 * WINDOW_MAX + 100);
  localparam int PRW   = PW + RECIP_W;
  localparam int SW    = (HOSTS > MASK_W) ? HOSTS : MASK_W;

  state_t             state, state_next;
  cmd_t               cmd_r;
  logic [HOSTS-1:0]   sel, sel_in;
  logic [HW-1:0]      h;
  logic [TIME_W-1:0]  t_r, old_r, best;
  logic [CW-1:0]      n_r, i_r;
  logic               found;
  stat_step_t         step;
  logic [PW-1:0]      x_r;
  logic [PRW-1:0]     prod_r;
  logic [WL_W-1:0]    wl;
  logic [RANK_W-1:0]  rank;
  logic [CW-1:0]      held [HOSTS];
  logic [IW-1:0]      head [HOSTS];
  logic [COUNT_W-1:0] res_count;
  logic [TIME_W-1:0]  res_min, res_max, res_p50, res_p90, res_p99;

  logic [CW-1:0]      cap, n_h, di, q, qm;
  logic [IW-1:0]      head_h, ring_wr_idx, head_inc, stat_idx;
  logic [CW:0]        ring_sum;
  logic [AW-1:0]      base;
  logic [SW-1:0]      mask_ext;
  logic               host_go, last_h, is_add, full_h, advance, finish_add;
  logic               rd_ge_old, rd_ge_t, req_fire, cfg_fire, host_ok, one_host, held_zero;
  logic [6:0]         pct_k;

  logic               s_we, r_we;
  logic [AW-1:0]      s_waddr, s_raddr, r_waddr, r_raddr;
  logic [TIME_W-1:0]  s_wdata, s_rdata, r_wdata, r_rdata;

  // sorted copy and arrival ring, one row of WINDOW_MAX per host
  swrt_ram #(.WIDTH(TIME_W), .DEPTH(DEPTH)) u_sorted (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata)
  );

  swrt_ram #(.WIDTH(TIME_W), .DEPTH(DEPTH)) u_ring (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata), .raddr(r_raddr), .rdata(r_rdata)
  );

  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid && cfg.ready;
  assign req_fire  = req.valid && req.ready;

  // effective window, clipped to the row size
  assign cap = (CAPW'(wl) > CAPW'(WINDOW_MAX)) ? CW'(WINDOW_MAX) : CW'(wl);

  // host selection for the word being accepted
  assign mask_ext = SW'(req.host_mask);
  assign one_host = (req.command == CMD_ADD_ONE) || (req.command == CMD_PRED_ONE);
  assign host_ok  = int'(req.host_index) < HOSTS;
  always_comb begin
    for (int k = 0; k < HOSTS; k++) begin
      sel_in[k] = one_host ? (int'(req.host_index) == k) : mask_ext[k];
    end
  end

  // per-host view of the current host
  assign n_h     = held[h];
  assign head_h  = head[h];
  assign base    = AW'(int'(h) * WINDOW_MAX);
  assign last_h  = (int'(h) == HOSTS - 1);
  assign is_add  = (cmd_r == CMD_ADD_ONE) || (cmd_r == CMD_ADD_MASK);
  assign full_h  = (n_h == cap);
  assign host_go = sel[h] && (is_add ? (cap != '0) : (int'(rank) < int'(n_h)));

  // ring positions
  assign ring_sum    = {1'b0, CW'(head_h)} + {1'b0, n_h};
  assign ring_wr_idx = (ring_sum >= {1'b0, cap}) ? IW'(ring_sum - {1'b0, cap}) : IW'(ring_sum);
  assign head_inc    = ((CW'(head_h) + CW'(1)) == cap) ? '0 : IW'(head_h + IW'(1));

  assign di        = i_r - CW'(1);
  assign rd_ge_old = s_rdata >= old_r;
  assign rd_ge_t   = s_rdata >= t_r;

  // percentile index from the reciprocal product
  assign q  = CW'(prod_r >> RECIP_SHIFT);
  assign qm = (q == '0) ? '0 : q - CW'(1);
  always_comb begin
    case (step)
      STEP_MIN: stat_idx = '0;
      STEP_MAX: stat_idx = IW'(n_r - CW'(1));
      default:  stat_idx = (qm > n_r - CW'(1)) ? IW'(n_r - CW'(1)) : IW'(qm);
    endcase
  end

  always_comb begin
    case (step)
      STEP_P50: pct_k = PCT_MID;
      STEP_P90: pct_k = PCT_HIGH;
      default:  pct_k = PCT_TOP;
    endcase
  end

  // sequencer: next state and ram strobes
  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    s_we       = 1'b0;
    s_waddr    = base;
    s_wdata    = t_r;
    s_raddr    = base;
    r_we       = 1'b0;
    r_waddr    = base;
    r_wdata    = t_r;
    r_raddr    = base;
    advance    = 1'b0;
    finish_add = 1'b0;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          case (req.command)
            CMD_ADD_ONE, CMD_ADD_MASK, CMD_PRED_ONE, CMD_PRED_MASK: state_next = ST_HOST;
            CMD_STATS: state_next = host_ok ? ST_STAT_CHK : ST_EMIT;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_HOST: begin
        if (host_go) begin
          if (is_add) begin
            if (full_h) begin
              r_raddr    = base + AW'(head_h);
              state_next = ST_ADD_OLD;
            end else begin
              r_we       = 1'b1;
              r_waddr    = base + AW'(ring_wr_idx);
              state_next = ST_INS_GO;
            end
          end else begin
            s_raddr    = base + AW'(n_h - CW'(1) - CW'(rank));
            state_next = ST_PRED_CMP;
          end
        end else begin
          advance = 1'b1;
        end
      end
      ST_ADD_OLD: begin
        // oldest sample comes out, new one takes its ring slot
        r_we       = 1'b1;
        r_waddr    = base + AW'(head_h);
        s_raddr    = base;
        state_next = ST_REM;
      end
      ST_REM: begin
        // drop the oldest from the sorted copy, shifting down above it
        if (found) begin
          s_we    = 1'b1;
          s_waddr = base + AW'(di - CW'(1));
          s_wdata = s_rdata;
        end
        if (di == n_r - CW'(1)) begin
          state_next = ST_INS_GO;
        end else begin
          s_raddr = base + AW'(i_r);
        end
      end
      ST_INS_GO: begin
        if (n_r == '0) begin
          s_we       = 1'b1;
          s_waddr    = base;
          finish_add = 1'b1;
          advance    = 1'b1;
        end else begin
          s_raddr    = base + AW'(n_r - CW'(1));
          state_next = ST_INS;
        end
      end
      ST_INS: begin
        // shift up from the top until the slot for the new sample
        s_we    = 1'b1;
        s_waddr = base + AW'(i_r);
        if (rd_ge_t) begin
          s_wdata = s_rdata;
          if (i_r == CW'(1)) begin
            state_next = ST_INS_LAST;
          end else begin
            s_raddr = base + AW'(i_r - CW'(2));
          end
        end else begin
          finish_add = 1'b1;
          advance    = 1'b1;
        end
      end
      ST_INS_LAST: begin
        s_we       = 1'b1;
        s_waddr    = base;
        finish_add = 1'b1;
        advance    = 1'b1;
      end
      ST_PRED_CMP: advance = 1'b1;
      ST_STAT_CHK: state_next = (n_h == '0) ? ST_EMIT : ST_STAT_X;
      ST_STAT_X: state_next = ST_STAT_MUL;
      ST_STAT_MUL: state_next = ST_STAT_RD;
      ST_STAT_RD: begin
        s_raddr    = base + AW'(stat_idx);
        state_next = ST_STAT_CAP;
      end
      ST_STAT_CAP: state_next = (step == STEP_P99) ? ST_EMIT : ST_STAT_X;
      ST_EMIT: begin
        if (!rsp.valid || rsp.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    if (advance) begin
      state_next = last_h ? (is_add ? ST_IDLE : ST_EMIT) : ST_HOST;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // registers, counts, ring heads and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      wl        <= WL_RESET;
      rank      <= '0;
      rsp.valid <= 1'b0;
      for (int k = 0; k < HOSTS; k++) begin
        held[k] <= '0;
        head[k] <= '0;
      end
    end else begin
      if (state == ST_EMIT && (!rsp.valid || rsp.ready)) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (cfg_fire && cfg.index == CFG_WINDOW_LENGTH) begin
        wl <= cfg.data[WL_W-1:0];
        for (int k = 0; k < HOSTS; k++) begin
          held[k] <= '0;
          head[k] <= '0;
        end
      end else begin
        if (finish_add) begin
          held[h] <= n_r + CW'(1);
        end
        if (state == ST_ADD_OLD) begin
          head[h] <= head_inc;
        end
      end
      if (cfg_fire && cfg.index == CFG_RANK_FROM_TOP) begin
        rank <= cfg.data[RANK_W-1:0];
      end
    end
  end

  // working datapath
  always_ff @(posedge clk) begin
    if (req_fire) begin
      cmd_r     <= req.command;
      t_r       <= req.sample_time;
      sel       <= sel_in;
      h         <= (req.command == CMD_STATS) ? HW'(req.host_index) : '0;
      best      <= '0;
      res_count <= '0;
      res_min   <= '0;
      res_max   <= '0;
      res_p50   <= '0;
      res_p90   <= '0;
      res_p99   <= '0;
    end
    if (advance && !last_h) begin
      h <= h + HW'(1);
    end
    case (state)
      ST_HOST: begin
        if (host_go && is_add) begin
          n_r <= n_h;
        end
      end
      ST_ADD_OLD: begin
        old_r <= r_rdata;
        i_r   <= CW'(1);
        found <= 1'b0;
      end
      ST_REM: begin
        if (!found && (rd_ge_old || di == n_r - CW'(1))) begin
          found <= 1'b1;
        end
        if (di == n_r - CW'(1)) begin
          n_r <= n_r - CW'(1);
        end else begin
          i_r <= i_r + CW'(1);
        end
      end
      ST_INS_GO: i_r <= n_r;
      ST_INS: begin
        if (rd_ge_t) begin
          i_r <= i_r - CW'(1);
        end
      end
      ST_PRED_CMP: begin
        if (s_rdata > best) begin
          best <= s_rdata;
        end
      end
      ST_STAT_CHK: begin
        n_r       <= n_h;
        res_count <= COUNT_W'(n_h);
        step      <= STEP_MIN;
      end
      ST_STAT_X: x_r <= PW'(pct_k) * PW'(n_r) + PW'(PCT_ROUND);
      ST_STAT_MUL: prod_r <= PRW'(x_r) * PRW'(RECIP_100);
      ST_STAT_CAP: begin
        case (step)
          STEP_MIN: res_min <= s_rdata;
          STEP_MAX: res_max <= s_rdata;
          STEP_P50: res_p50 <= s_rdata;
          STEP_P90: res_p90 <= s_rdata;
          default:  res_p99 <= s_rdata;
        endcase
        step <= stat_step_t'(3'(step) + 3'd1);
      end
      ST_EMIT: begin
        if (!rsp.valid || rsp.ready) begin
          rsp.predicted_time <= best;
          rsp.sample_count   <= res_count;
          rsp.min_time       <= res_min;
          rsp.max_time       <= res_max;
          rsp.p50_time       <= res_p50;
          rsp.p90_time       <= res_p90;
          rsp.p99_time       <= res_p99;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    held_zero = 1'b1;
    for (int k = 0; k < HOSTS; k++) begin
      if (held[k] != '0) begin
        held_zero = 1'b0;
      end
    end
  end

  // window length write empties every host
  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_fire && cfg.index == CFG_WINDOW_LENGTH |=> held_zero)
    else $error("window length write did not empty the windows");

  // an accepted add starts the host walk
  a_add_start: assert property (@(posedge clk) disable iff (rst)
    req_fire && (req.command == CMD_ADD_ONE || req.command == CMD_ADD_MASK)
    |=> state == ST_HOST)
    else $error("add word did not start the host walk");

  // eviction only runs on a non-empty window
  a_rem_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_REM |-> n_r != '0)
    else $error("eviction with empty window");

  // last statistic leads straight to the response
  a_stat_emit: assert property (@(posedge clk) disable iff (rst)
    state == ST_STAT_CAP && step == STEP_P99 |=> state == ST_EMIT)
    else $error("statistics did not end in a response");

endmodule

`default_nettype wire

### test/sliding_window_rank_tracker_tb.sv
// testbench for sliding_window_rank_tracker: directed and random command words
// checked against an in-bench window/rank predictor; needs swrt_pkg and swrt_if
`timescale 1ns / 100ps

module sliding_window_rank_tracker_tb;
  import swrt_pkg::*;

  localparam int WMAX = 64;
  localparam int NHOST = 8;
  localparam int QUIET_LIMIT = 20000;

  typedef struct packed {
    logic [31:0] pred;
    logic [6:0]  cnt;
    logic [31:0] mn;
    logic [31:0] mx;
    logic [31:0] p50;
    logic [31:0] p90;
    logic [31:0] p99;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  swrt_req_if req ();
  swrt_rsp_if rsp ();
  swrt_cfg_if cfg ();

  sliding_window_rank_tracker dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg));

  always #2 clk = ~clk;

  // predictor state
  logic [6:0]  win_len;
  logic [5:0]  rank_top;
  logic [31:0] sorted_q [NHOST][$];
  logic [31:0] arrival_q [NHOST][$];

  answer_t answer_q [$];
  int errors = 0;
  int quiet = 0;
  bit idle_on = 1'b1;

  function automatic int cap_now();
    return (win_len > WMAX) ? WMAX : int'(win_len);
  endfunction

  function automatic void insert_sorted(int h, logic [31:0] t);
    int p;
    p = 0;
    while (p < sorted_q[h].size() && sorted_q[h][p] < t) p++;
    sorted_q[h].insert(p, t);
  endfunction

  function automatic void window_add(int h, logic [31:0] t);
    logic [31:0] old;
    int p;
    if (cap_now() == 0) return;
    if (arrival_q[h].size() == cap_now()) begin
      old = arrival_q[h].pop_front();
      p = 0;
      while (p < sorted_q[h].size() && sorted_q[h][p] < old) p++;
      if (p >= sorted_q[h].size()) p = sorted_q[h].size() - 1;
      sorted_q[h].delete(p);
    end
    arrival_q[h].push_back(t);
    insert_sorted(h, t);
  endfunction

  function automatic logic [31:0] rank_value(int h);
    int n;
    n = sorted_q[h].size();
    if (int'(rank_top) >= n) return '0;
    return sorted_q[h][n - 1 - rank_top];
  endfunction

  function automatic logic [31:0] percentile(int h, int k);
    int n, idx;
    n = sorted_q[h].size();
    idx = (k * n + 99) / 100;
    idx = (idx > 0) ? idx - 1 : 0;
    if (idx > n - 1) idx = n - 1;
    return sorted_q[h][idx];
  endfunction

  // apply one command word to the predictor, queue the answer if any
  function automatic void predict_word(cmd_t c, logic [2:0] h, logic [7:0] m, logic [31:0] t);
    answer_t a;
    logic [31:0] v;
    int n;
    a = '0;
    case (c)
      CMD_ADD_ONE: begin
        window_add(int'(h), t);
        return;
      end
      CMD_ADD_MASK: begin
        for (int i = 0; i < NHOST; i++) if (m[i]) window_add(i, t);
        return;
      end
      CMD_PRED_ONE: a.pred = rank_value(int'(h));
      CMD_PRED_MASK: begin
        if (int'(rank_top) < cap_now())
          for (int i = 0; i < NHOST; i++)
            if (m[i]) begin
              v = rank_value(i);
              if (v > a.pred) a.pred = v;
            end
      end
      CMD_STATS: begin
        n = sorted_q[h].size();
        if (n > 0) begin
          a.cnt = 7'(n);
          a.mn = sorted_q[h][0];
          a.mx = sorted_q[h][n - 1];
          a.p50 = percentile(int'(h), 50);
          a.p90 = percentile(int'(h), 90);
          a.p99 = percentile(int'(h), 99);
        end
      end
      default: return;
    endcase
    answer_q.push_back(a);
  endfunction

  // send one command word; valid stays up after the accepting edge until the
  // next word, an idle cycle or a drain takes it down
  task automatic send_word(cmd_t c, logic [2:0] h, logic [7:0] m, logic [31:0] t);
    while (idle_on && $urandom_range(99) < 21) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.command <= c;
    req.host_index <= h;
    req.host_mask <= m;
    req.sample_time <= t;
    // ready only moves at the rising edge, so sample it mid-cycle
    @(negedge clk);
    while (!req.ready) @(negedge clk);
    @(posedge clk);
    predict_word(c, h, m, t);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  // register write; only called with the block drained
  task automatic write_reg(cfg_idx_t idx, logic [6:0] d);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= d;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    if (idx == CFG_WINDOW_LENGTH) begin
      win_len = d;
      for (int i = 0; i < NHOST; i++) begin
        sorted_q[i].delete();
        arrival_q[i].delete();
      end
    end else if (idx == CFG_RANK_FROM_TOP) begin
      rank_top = d[5:0];
    end
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_time();
    case ($urandom_range(5))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_words(int count, int add_pct);
    cmd_t c;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < add_pct) c = ($urandom_range(3) == 0) ? CMD_ADD_MASK : CMD_ADD_ONE;
      else if (r < add_pct + 3) c = cmd_t'($urandom_range(7, 5));
      else c = cmd_t'($urandom_range(4, 2));
      send_word(c, 3'($urandom_range(7)), 8'($urandom_range(255)), rand_time());
    end
  endtask

  // directed: field extremes, every command, empty and disabled cases
  task automatic test_directed();
    send_word(CMD_STATS, 3'd0, 8'h00, '0);
    send_word(CMD_PRED_ONE, 3'd7, 8'h00, '0);
    send_word(CMD_PRED_MASK, 3'd0, 8'h00, '0);
    send_word(CMD_ADD_ONE, 3'd0, 8'h00, 32'hFFFF_FFFF);
    send_word(CMD_ADD_ONE, 3'd0, 8'h00, 32'h0);
    send_word(CMD_ADD_ONE, 3'd7, 8'hFF, 32'h5);
    send_word(CMD_ADD_MASK, 3'd0, 8'hFF, 32'h1234);
    send_word(CMD_ADD_MASK, 3'd7, 8'h00, 32'h99);
    send_word(3'd5, 3'd7, 8'hFF, 32'hFFFF_FFFF);
    send_word(3'd6, 3'd0, 8'h00, 32'h0);
    send_word(3'd7, 3'd3, 8'hAA, 32'h1);
    send_word(CMD_STATS, 3'd0, 8'hFF, '0);
    send_word(CMD_STATS, 3'd7, 8'h00, '0);
    send_word(CMD_PRED_ONE, 3'd0, 8'h00, '0);
    send_word(CMD_PRED_MASK, 3'd7, 8'hFF, '0);
    send_word(CMD_PRED_MASK, 3'd0, 8'h55, '0);
    drain();
    write_reg(CFG_RANK_FROM_TOP, 7'd63);
    send_word(CMD_PRED_ONE, 3'd0, 8'h00, '0);
    send_word(CMD_PRED_MASK, 3'd0, 8'hFF, '0);
    drain();
    write_reg(CFG_WINDOW_LENGTH, 7'd0);
    write_reg(CFG_RANK_FROM_TOP, 7'd0);
    send_word(CMD_ADD_ONE, 3'd1, 8'h00, 32'h10);
    send_word(CMD_PRED_ONE, 3'd1, 8'h00, '0);
    send_word(CMD_PRED_MASK, 3'd1, 8'hFF, '0);
    send_word(CMD_STATS, 3'd1, 8'h00, '0);
    drain();
  endtask

  // full window of 64 with eviction and high ranks
  task automatic test_full_window();
    write_reg(CFG_WINDOW_LENGTH, 7'd64);
    write_reg(CFG_RANK_FROM_TOP, 7'd63);
    random_words(220, 70);
    drain();
  endtask

  // window longer than the maximum, clipped
  task automatic test_clipped_window();
    write_reg(CFG_WINDOW_LENGTH, 7'd127);
    write_reg(CFG_RANK_FROM_TOP, 7'd2);
    idle_on = 1'b0;
    random_words(180, 60);
    idle_on = 1'b1;
    drain();
  endtask

  // short windows with many evictions and random ranks
  task automatic test_short_windows();
    for (int k = 0; k < 6; k++) begin
      write_reg(CFG_WINDOW_LENGTH, 7'($urandom_range(1, 9)));
      write_reg(CFG_RANK_FROM_TOP, 7'($urandom_range(0, 9)));
      random_words(100, 55);
      drain();
    end
  endtask

  // response side back-pressure
  always @(posedge clk) begin
    rsp.ready <= idle_on ? ($urandom_range(99) >= 21) : 1'b1;
  end

  // answer checker and watchdog
  always @(posedge clk) begin
    answer_t e;
    if (rst) begin
      quiet <= 0;
    end else begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
      if (rsp.valid && rsp.ready) begin
        if (answer_q.size() == 0) begin
          $error("result word with no expectation");
          errors++;
        end else begin
          e = answer_q.pop_front();
          if (rsp.predicted_time !== e.pred) begin
            $error("predicted_time exp %0h got %0h", e.pred, rsp.predicted_time); errors++;
          end
          if (rsp.sample_count !== e.cnt) begin
            $error("sample_count exp %0d got %0d", e.cnt, rsp.sample_count); errors++;
          end
          if (rsp.min_time !== e.mn) begin
            $error("min_time exp %0h got %0h", e.mn, rsp.min_time); errors++;
          end
          if (rsp.max_time !== e.mx) begin
            $error("max_time exp %0h got %0h", e.mx, rsp.max_time); errors++;
          end
          if (rsp.p50_time !== e.p50) begin
            $error("p50_time exp %0h got %0h", e.p50, rsp.p50_time); errors++;
          end
          if (rsp.p90_time !== e.p90) begin
            $error("p90_time exp %0h got %0h", e.p90, rsp.p90_time); errors++;
          end
          if (rsp.p99_time !== e.p99) begin
            $error("p99_time exp %0h got %0h", e.p99, rsp.p99_time); errors++;
          end
        end
      end
    end
  end

  initial begin
    req.valid = 1'b0;
    req.command = '0;
    req.host_index = '0;
    req.host_mask = '0;
    req.sample_time = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    rsp.ready = 1'b0;
    win_len = WL_RESET;
    rank_top = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_window();
    test_clipped_window();
    test_short_windows();
    drain();
    if (errors == 0 && answer_q.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/swrt_pkg.sv
hw/rtl/swrt_if.sv
hw/rtl/swrt_ram.sv
hw/rtl/sliding_window_rank_tracker.sv
test/sliding_window_rank_tracker_tb.sv
